// ----- src/sparse_column_scatter_accumulate_assert.svh -----
// Assertion macros for the scatter-accumulate block.
`ifndef SPARSE_COLUMN_SCATTER_ACCUMULATE_ASSERT_SVH
`define SPARSE_COLUMN_SCATTER_ACCUMULATE_ASSERT_SVH

// Same-cycle implication.
`define SCSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scsa assertion failed");

// Next-cycle implication.
`define SCSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scsa assertion failed");

`endif

// ----- src/scsa_pkg.sv -----
`default_nettype none
package scsa_pkg;

  localparam int NUM_ROWS  = 65536;
  localparam int ACC_WIDTH = 40;

  localparam int OP_W   = 2;
  localparam int ROW_W  = 16;
  localparam int COEF_W = 16;
  localparam int PIX_W  = 16;
  localparam int ROW_AW = $clog2(NUM_ROWS);

  // unsigned coef times signed pixel, exact
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

  localparam logic signed [SUM_W-1:0] ACC_HI =
    signed'({{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int RESQ_DEPTH = 2;
  localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ACC  = 2'd0,
    OP_CLR  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACC,
    KIND_CLR,
    KIND_RD,
    KIND_RD_ZERO
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    kind_e                     kind;
    logic [ROW_AW-1:0]         addr;
    logic [COEF_W-1:0]         coef;
    logic signed [PIX_W-1:0]   pix;
  } cmd_t;

  typedef struct packed {
    logic                        sat;
    logic signed [ACC_WIDTH-1:0] acc;
  } entry_t;

  typedef struct packed {
    logic [ACC_WIDTH-1:0] row_sum;
    logic                 saturated;
  } result_t;

endpackage
`default_nettype wire

// ----- src/sparse_column_scatter_accumulate.sv -----
// Channel   Handshake          Payload
// input     push_i / full_o    operation_i, row_index_i, coefficient_i, pixel_value_i
// result    pop_i / empty_o    row_sum_o, saturated_o
//
// Accumulates and in-range reads do an accumulator memory read in the back end, then
// add-and-writeback or result push; clears and out-of-range reads end in idle. The
// single-port accumulator memory sets this. A 4-entry command queue decouples the
// input; full_o rises when it fills. Reset clears queues and control only; each row
// holds an undefined value until cleared. A stalled pop fills the 2-entry result
// queue; the next read then waits in the back end and holds up all behind it.
`default_nettype none
module sparse_column_scatter_accumulate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [scsa_pkg::OP_W-1:0]       operation_i,
  input  logic [scsa_pkg::ROW_W-1:0]      row_index_i,
  input  logic [scsa_pkg::COEF_W-1:0]     coefficient_i,
  input  logic signed [scsa_pkg::PIX_W-1:0] pixel_value_i,
  output logic                            empty_o,
  input  logic                            pop_i,
  output logic [scsa_pkg::ACC_WIDTH-1:0]  row_sum_o,
  output logic                            saturated_o
);
  import scsa_pkg::*;

  logic    cmd_valid, cmd_ready, res_valid, res_ready;
  cmd_t    cmd;
  result_t res;

  scsa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .operation_i   (operation_i),
    .row_index_i   (row_index_i),
    .coefficient_i (coefficient_i),
    .pixel_value_i (pixel_value_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_ready_i   (cmd_ready)
  );

  scsa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  scsa_resq u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .row_sum_o   (row_sum_o),
    .saturated_o (saturated_o)
  );

endmodule
`default_nettype wire

// ----- src/scsa_front.sv -----
`default_nettype none
module scsa_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [scsa_pkg::OP_W-1:0]   operation_i,
  input  logic [scsa_pkg::ROW_W-1:0]  row_index_i,
  input  logic [scsa_pkg::COEF_W-1:0] coefficient_i,
  input  logic signed [scsa_pkg::PIX_W-1:0] pixel_value_i,
  output logic                        cmd_valid_o,
  output scsa_pkg::cmd_t              cmd_o,
  input  logic                        cmd_ready_i
);
  import scsa_pkg::*;

  cmd_t               q_mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_AW:0]   count_q, count_d;
  logic               row_ok, keep, enq, deq;
  kind_e              kind;
  cmd_t               cmd_new;

  assign row_ok = 32'(row_index_i) < NUM_ROWS;

  always_comb begin
    keep = 1'b0;
    kind = KIND_ACC;
    unique case (op_e'(operation_i))
      OP_ACC: begin
        keep = row_ok;
        kind = KIND_ACC;
      end
      OP_CLR: begin
        keep = row_ok;
        kind = KIND_CLR;
      end
      OP_READ: begin
        keep = 1'b1;
        kind = row_ok ? KIND_RD : KIND_RD_ZERO;
      end
      default: begin
        keep = 1'b0;
        kind = KIND_ACC;
      end
    endcase
  end

  always_comb begin
    cmd_new.kind = kind;
    cmd_new.addr = ROW_AW'(row_index_i);
    cmd_new.coef = coefficient_i;
    cmd_new.pix  = pixel_value_i;
  end

  assign full_o      = count_q == (CMDQ_AW+1)'(CMDQ_DEPTH);
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign enq         = push_i & ~full_o & keep;
  assign deq         = cmd_valid_o & cmd_ready_i;

  always_comb begin
    count_d = count_q;
    if (enq && !deq) begin
      count_d = count_q + 1'b1;
    end else if (deq && !enq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (enq) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (deq) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) q_mem[wr_ptr_q] <= cmd_new;
  end

endmodule
`default_nettype wire

// ----- src/scsa_back.sv -----
`default_nettype none
module scsa_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  scsa_pkg::cmd_t    cmd_i,
  output logic              cmd_ready_o,
  output logic              res_valid_o,
  output scsa_pkg::result_t res_o,
  input  logic              res_ready_i
);
  import scsa_pkg::*;

  entry_t mem [NUM_ROWS];

  state_e                    state_q, state_d;
  kind_e                     kind_q;
  logic [ROW_AW-1:0]         addr_q, mem_waddr;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  entry_t                    rdata_q, mem_wdata;
  logic                      mem_we, mem_re;
  logic signed [SUM_W-1:0]   sum;
  logic                      ovf_hi, ovf_lo;
  logic [ACC_WIDTH-1:0]      clipped;

  assign prod_d = PROD_W'(signed'({1'b0, cmd_i.coef})) * PROD_W'(cmd_i.pix);

  assign sum    = SUM_W'(rdata_q.acc) + SUM_W'(prod_q);
  assign ovf_hi = sum > ACC_HI;
  assign ovf_lo = sum < ACC_LO;

  always_comb begin
    if (ovf_hi) begin
      clipped = ACC_HI[ACC_WIDTH-1:0];
    end else if (ovf_lo) begin
      clipped = ACC_LO[ACC_WIDTH-1:0];
    end else begin
      clipped = sum[ACC_WIDTH-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = cmd_i.addr;
    mem_wdata   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            KIND_CLR: begin
              cmd_ready_o = 1'b1;
              mem_we      = 1'b1;
            end
            KIND_RD_ZERO: begin
              res_valid_o = 1'b1;
              cmd_ready_o = res_ready_i;
            end
            KIND_ACC, KIND_RD: begin
              cmd_ready_o = 1'b1;
              mem_re      = 1'b1;
              state_d     = ST_EXEC;
            end
            default: begin
              cmd_ready_o = 1'b0;
            end
          endcase
        end
      end
      ST_EXEC: begin
        mem_waddr = addr_q;
        if (kind_q == KIND_ACC) begin
          mem_we        = 1'b1;
          mem_wdata.sat = rdata_q.sat | ovf_hi | ovf_lo;
          mem_wdata.acc = clipped;
          state_d       = ST_IDLE;
        end else begin
          res_valid_o       = 1'b1;
          res_o.row_sum     = rdata_q.acc;
          res_o.saturated   = rdata_q.sat;
          if (res_ready_i) state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      kind_q  <= cmd_i.kind;
      addr_q  <= cmd_i.addr;
      prod_q  <= prod_d;
      rdata_q <= mem[cmd_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

endmodule
`default_nettype wire

// ----- src/scsa_resq.sv -----
`default_nettype none
module scsa_resq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           res_valid_i,
  input  scsa_pkg::result_t              res_i,
  output logic                           res_ready_o,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [scsa_pkg::ACC_WIDTH-1:0] row_sum_o,
  output logic                           saturated_o
);
  import scsa_pkg::*;

  result_t            q_mem [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RESQ_AW:0]   count_q, count_d;
  logic               enq, deq;
  result_t            head;

  assign res_ready_o = count_q != (RESQ_AW+1)'(RESQ_DEPTH);
  assign empty_o     = count_q == '0;
  assign enq         = res_valid_i & res_ready_o;
  assign deq         = pop_i & ~empty_o;
  assign head        = q_mem[rd_ptr_q];
  assign row_sum_o   = head.row_sum;
  assign saturated_o = head.saturated;

  always_comb begin
    count_d = count_q;
    if (enq && !deq) begin
      count_d = count_q + 1'b1;
    end else if (deq && !enq) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (enq) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (deq) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) q_mem[wr_ptr_q] <= res_i;
  end

endmodule
`default_nettype wire

// ----- src/scsa_checker.sv -----
`default_nettype none
`include "sparse_column_scatter_accumulate_assert.svh"
module scsa_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            full_o,
  input  logic [scsa_pkg::OP_W-1:0]       operation_i,
  input  logic                            empty_o,
  input  logic                            pop_i,
  input  logic [scsa_pkg::ACC_WIDTH-1:0]  row_sum_o,
  input  logic                            saturated_o
);
  import scsa_pkg::*;

  // reads accepted whose result has not yet been popped
  logic [7:0] pend_q;
  logic       rd_in, rd_out;

  assign rd_in  = push_i && !full_o && (operation_i == OP_READ);
  assign rd_out = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (rd_in && !rd_out) begin
      pend_q <= pend_q + 1'b1;
    end else if (rd_out && !rd_in) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `SCSA_ASSERT_NXT(a_res_hold, clk_i, rst_ni, !empty_o && !pop_i,
    !empty_o && $stable(row_sum_o) && $stable(saturated_o))
  `SCSA_ASSERT_IMP(a_res_has_read, clk_i, rst_ni, !empty_o, pend_q != '0)
  `SCSA_ASSERT_NXT(a_res_not_early, clk_i, rst_ni, pend_q == '0, empty_o)

endmodule

bind sparse_column_scatter_accumulate scsa_checker u_scsa_checker (.*);
`default_nettype wire
